/* sv/rsh_pkg.sv */
// Shared types, constants and codes for the rolling substring hash block.
package rsh_pkg;

  // String store sizing.
  localparam int MAX_LEN = 1024;
  localparam int POS_W = $clog2(MAX_LEN + 1);
  localparam int CHAR_AW = $clog2(MAX_LEN);
  localparam int TAB_DEPTH = MAX_LEN + 1;
  localparam int CHAR_W = 8;

  // Hash arithmetic widths.
  localparam int HW = 30;
  localparam int PROD_W = 2 * HW;
  localparam int X_W = 65;
  localparam int RED_STEPS = 4;
  localparam int RED_CYC = (X_W - 1) / RED_STEPS;
  localparam int RED_CNT_W = $clog2(RED_CYC);

  // Configuration registers.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE = 1'b1;
  localparam logic [HW-1:0] MODULUS_RST = 30'd998244353;
  localparam logic [HW-1:0] BASE_RST = 30'd131;

  // Request function codes.
  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_HASH = 2'd1;
  localparam logic [1:0] FUNC_CMP = 2'd2;
  localparam logic [1:0] FUNC_PAL = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_NOREV = 2'd2;

  // A decoded request as it travels from the front end to the back end.
  typedef struct packed {
    logic [1:0]               func;
    logic signed [CHAR_W-1:0] char_value;
    logic                     last_char;
    logic [POS_W-1:0]         start_one;
    logic [POS_W-1:0]         end_one;
    logic [POS_W-1:0]         start_two;
    logic [POS_W-1:0]         end_two;
    logic                     ord_one;
    logic                     ord_two;
    logic [POS_W-1:0]         len_one;
    logic [POS_W-1:0]         len_two;
  } cmd_t;

  // Request to the modular multiply-add unit: (a*b + c) or (c - a*b), mod m.
  typedef struct packed {
    logic               start;
    logic [HW-1:0]      a;
    logic [HW-1:0]      b;
    logic signed [HW:0] c;
    logic               neg;
  } mad_req_t;

  typedef struct packed {
    logic          busy;
    logic          done;
    logic [HW-1:0] res;
  } mad_rsp_t;

endpackage

/* sv/rolling_substring_hash.sv */
// Top level of the rolling substring hash block: configuration and front/back ends.
// Requests enter through a two-entry queue and run one at a time on a shared
// modular multiply-add unit, which reduces the 64-bit product sum four bits per
// cycle. A load runs two multiply-adds; the load marked last then runs one more
// per stored character for the reverse walk. A substring hash runs one
// multiply-add, a compare or palindrome check two, and the result then goes to
// the output register once it is free. Configuration is written through
// cfg_valid/cfg_ready, which is always ready; index 0 is the modulus and index 1
// the base.
module rolling_substring_hash (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  output logic                              full,
  input  logic [1:0]                        in_func,
  input  logic signed [rsh_pkg::CHAR_W-1:0] in_char_value,
  input  logic                              in_last_char,
  input  logic [rsh_pkg::POS_W-1:0]         in_start_one,
  input  logic [rsh_pkg::POS_W-1:0]         in_end_one,
  input  logic [rsh_pkg::POS_W-1:0]         in_start_two,
  input  logic [rsh_pkg::POS_W-1:0]         in_end_two,
  output logic                              empty,
  input  logic                              pop,
  output logic [rsh_pkg::HW-1:0]            out_hash_value,
  output logic                              out_answer_flag,
  output logic [1:0]                        out_status,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rsh_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rsh_pkg::HW-1:0]            cfg_data
);

  logic [rsh_pkg::HW-1:0] modulus_r, modulus_nxt, base_r, base_nxt;
  logic cmd_valid, cmd_pop;
  rsh_pkg::cmd_t cmd;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_comb begin
    modulus_nxt = modulus_r;
    base_nxt = base_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        rsh_pkg::CFG_MODULUS: modulus_nxt = cfg_data;
        rsh_pkg::CFG_BASE:    base_nxt = cfg_data;
        default:              modulus_nxt = modulus_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= rsh_pkg::MODULUS_RST;
      base_r <= rsh_pkg::BASE_RST;
    end else begin
      modulus_r <= modulus_nxt;
      base_r <= base_nxt;
    end
  end

  rsh_front u_front (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_func(in_func), .in_char_value(in_char_value), .in_last_char(in_last_char),
    .in_start_one(in_start_one), .in_end_one(in_end_one),
    .in_start_two(in_start_two), .in_end_two(in_end_two),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop)
  );

  rsh_back u_back (
    .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop),
    .modulus(modulus_r), .base(base_r), .empty(empty), .pop(pop),
    .hash_value(out_hash_value), .answer_flag(out_answer_flag), .status(out_status)
  );

endmodule

/* sv/rsh_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module rsh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* sv/rsh_modmul.sv */
// Multi-cycle modular multiply-add unit with a bit-serial reduction.
module rsh_modmul (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rsh_pkg::mad_req_t     req,
  input  logic [rsh_pkg::HW-1:0] modulus,
  output rsh_pkg::mad_rsp_t     rsp
);

  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_MUL = 2'd1;
  localparam logic [1:0] M_ADD = 2'd2;
  localparam logic [1:0] M_RED = 2'd3;

  logic [1:0] st_r, st_nxt;
  logic [rsh_pkg::HW-1:0] a_r, a_nxt, b_r, b_nxt, m_r, m_nxt, acc_r, acc_nxt;
  logic signed [rsh_pkg::HW:0] c_r, c_nxt;
  logic neg_r, neg_nxt;
  logic [rsh_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic [rsh_pkg::X_W-2:0] sh_r, sh_nxt;
  logic [rsh_pkg::RED_CNT_W-1:0] cnt_r, cnt_nxt;
  logic done_r, done_nxt;

  logic [rsh_pkg::X_W-1:0] x_sum;
  logic [rsh_pkg::X_W-1:0] p_ext;
  logic [rsh_pkg::HW:0] t_step;
  logic [rsh_pkg::HW-1:0] acc_step;

  // The signed sum whose residue is wanted.
  assign p_ext = {{(rsh_pkg::X_W - rsh_pkg::PROD_W){1'b0}}, prod_r};
  assign x_sum = {{(rsh_pkg::X_W - rsh_pkg::HW - 1){c_r[rsh_pkg::HW]}}, c_r}
               + (neg_r ? (~p_ext + 1'b1) : p_ext);

  // Four Horner steps per cycle: r = (2r + bit) mod m, r stays below m.
  always_comb begin
    acc_step = acc_r;
    t_step = '0;
    for (int k = 0; k < rsh_pkg::RED_STEPS; k++) begin
      t_step = {acc_step, sh_r[rsh_pkg::X_W-2-k]};
      if (t_step >= {1'b0, m_r}) begin
        t_step = t_step - {1'b0, m_r};
      end
      acc_step = t_step[rsh_pkg::HW-1:0];
    end
  end

  // Sequencer: capture, multiply, add, reduce.
  always_comb begin
    st_nxt = st_r;
    a_nxt = a_r;
    b_nxt = b_r;
    c_nxt = c_r;
    neg_nxt = neg_r;
    m_nxt = m_r;
    prod_nxt = prod_r;
    sh_nxt = sh_r;
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    done_nxt = 1'b0;
    unique case (st_r)
      M_IDLE: begin
        if (req.start) begin
          a_nxt = req.a;
          b_nxt = req.b;
          c_nxt = req.c;
          neg_nxt = req.neg;
          // A modulus below two behaves as one.
          m_nxt = (modulus < rsh_pkg::HW'(2)) ? rsh_pkg::HW'(1) : modulus;
          st_nxt = M_MUL;
        end
      end
      M_MUL: begin
        prod_nxt = a_r * b_r;
        st_nxt = M_ADD;
      end
      M_ADD: begin
        // The sign bit weighs minus its power of two, so it seeds r with -1 mod m.
        acc_nxt = x_sum[rsh_pkg::X_W-1] ? (m_r - 1'b1) : '0;
        sh_nxt = x_sum[rsh_pkg::X_W-2:0];
        cnt_nxt = '0;
        st_nxt = M_RED;
      end
      M_RED: begin
        acc_nxt = acc_step;
        sh_nxt = sh_r << rsh_pkg::RED_STEPS;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == rsh_pkg::RED_CNT_W'(rsh_pkg::RED_CYC - 1)) begin
          done_nxt = 1'b1;
          st_nxt = M_IDLE;
        end
      end
      default: st_nxt = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= M_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      done_r <= done_nxt;
    end
    a_r <= a_nxt;
    b_r <= b_nxt;
    c_r <= c_nxt;
    neg_r <= neg_nxt;
    m_r <= m_nxt;
    prod_r <= prod_nxt;
    sh_r <= sh_nxt;
    acc_r <= acc_nxt;
    cnt_r <= cnt_nxt;
  end

  assign rsp.busy = (st_r != M_IDLE);
  assign rsp.done = done_r;
  assign rsp.res = acc_r;

endmodule

/* sv/rsh_front.sv */
// Front end: accepts requests, precomputes range order and length, queues them.
module rsh_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  output logic                           full,
  input  logic [1:0]                     in_func,
  input  logic signed [rsh_pkg::CHAR_W-1:0] in_char_value,
  input  logic                           in_last_char,
  input  logic [rsh_pkg::POS_W-1:0]      in_start_one,
  input  logic [rsh_pkg::POS_W-1:0]      in_end_one,
  input  logic [rsh_pkg::POS_W-1:0]      in_start_two,
  input  logic [rsh_pkg::POS_W-1:0]      in_end_two,
  output logic                           cmd_valid,
  output rsh_pkg::cmd_t                  cmd,
  input  logic                           cmd_pop
);

  rsh_pkg::cmd_t q_r [2];
  rsh_pkg::cmd_t dec;
  logic wr_r, wr_nxt, rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic do_push, do_pop;

  // Classify the incoming request.
  always_comb begin
    dec.func = in_func;
    dec.char_value = in_char_value;
    dec.last_char = in_last_char;
    dec.start_one = in_start_one;
    dec.end_one = in_end_one;
    dec.start_two = in_start_two;
    dec.end_two = in_end_two;
    dec.ord_one = (in_start_one <= in_end_one);
    dec.ord_two = (in_start_two <= in_end_two);
    dec.len_one = in_end_one - in_start_one;
    dec.len_two = in_end_two - in_start_two;
  end

  // Two-entry queue toward the back end.
  assign full = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd = q_r[rd_r];
  assign do_push = push && !full;
  assign do_pop = cmd_pop && cmd_valid;

  always_comb begin
    wr_nxt = wr_r ^ do_push;
    rd_nxt = rd_r ^ do_pop;
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= 1'b0;
      rd_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r <= wr_nxt;
      rd_r <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) begin
      q_r[wr_r] <= dec;
    end
  end

endmodule

/* sv/rsh_back.sv */
// Back end: table memories, load and reverse-walk sequencer, query evaluation.
module rsh_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cmd_valid,
  input  rsh_pkg::cmd_t            cmd,
  output logic                     cmd_pop,
  input  logic [rsh_pkg::HW-1:0]   modulus,
  input  logic [rsh_pkg::HW-1:0]   base,
  output logic                     empty,
  input  logic                     pop,
  output logic [rsh_pkg::HW-1:0]   hash_value,
  output logic                     answer_flag,
  output logic [1:0]               status
);

  localparam int PW = rsh_pkg::POS_W;
  localparam int HW = rsh_pkg::HW;

  localparam logic [3:0] S_FETCH = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_LD_RD = 4'd2;
  localparam logic [3:0] S_LD_PW = 4'd3;
  localparam logic [3:0] S_LD_PH = 4'd4;
  localparam logic [3:0] S_WALK = 4'd5;
  localparam logic [3:0] S_WALK_RD = 4'd6;
  localparam logic [3:0] S_WALK_W = 4'd7;
  localparam logic [3:0] S_H_A = 4'd8;
  localparam logic [3:0] S_H_B = 4'd9;
  localparam logic [3:0] S_H_C = 4'd10;
  localparam logic [3:0] S_H_W = 4'd11;
  localparam logic [3:0] S_OUT = 4'd12;

  logic [3:0] state_r, state_nxt;
  rsh_pkg::cmd_t cmd_r, cmd_nxt;
  logic [PW-1:0] len_r, len_nxt, n_r, n_nxt, i_r, i_nxt;
  logic done_r, done_nxt, which_r, which_nxt;
  logic [HW-1:0] tmp_r, tmp_nxt, acc_r, acc_nxt, h0_r, h0_nxt;
  logic [HW-1:0] tlo_r, tlo_nxt, pw_r, pw_nxt;
  logic [HW-1:0] res_hash_r, res_hash_nxt;
  logic res_flag_r, res_flag_nxt;
  logic [1:0] res_status_r, res_status_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [HW-1:0] out_hash_r, out_hash_nxt;
  logic out_flag_r, out_flag_nxt;
  logic [1:0] out_status_r, out_status_nxt;

  rsh_pkg::mad_req_t mad_req;
  rsh_pkg::mad_rsp_t mad_rsp;

  // Memory ports.
  logic char_we;
  logic [rsh_pkg::CHAR_AW-1:0] char_wa, char_ra;
  logic [rsh_pkg::CHAR_W-1:0] char_q;
  logic pre_we, pow_we, rev_we;
  logic [PW-1:0] pre_wa, pow_wa, rev_wa, pre_ra, pow_ra, rev_ra;
  logic [HW-1:0] pre_q, pow_q, rev_q;
  logic pre_z_r, pow_z_r, rev_z_r;
  logic [HW-1:0] pre_d, pow_d, rev_d;

  // Query selection and checks.
  logic [PW-1:0] n_eff, sel_lo, sel_hi, sel_plen, walk_idx;
  logic sel_rev, ok_one, ok_two, is_load;
  logic [HW-1:0] tab_d;

  rsh_ram #(.WIDTH(rsh_pkg::CHAR_W), .DEPTH(rsh_pkg::MAX_LEN)) u_char (
    .clk(clk), .wr_en(char_we), .wr_addr(char_wa), .wr_data(cmd_r.char_value),
    .rd_addr(char_ra), .rd_data(char_q)
  );
  rsh_ram #(.WIDTH(HW), .DEPTH(rsh_pkg::TAB_DEPTH)) u_prefix (
    .clk(clk), .wr_en(pre_we), .wr_addr(pre_wa), .wr_data(mad_rsp.res),
    .rd_addr(pre_ra), .rd_data(pre_q)
  );
  rsh_ram #(.WIDTH(HW), .DEPTH(rsh_pkg::TAB_DEPTH)) u_power (
    .clk(clk), .wr_en(pow_we), .wr_addr(pow_wa), .wr_data(mad_rsp.res),
    .rd_addr(pow_ra), .rd_data(pow_q)
  );
  rsh_ram #(.WIDTH(HW), .DEPTH(rsh_pkg::TAB_DEPTH)) u_reverse (
    .clk(clk), .wr_en(rev_we), .wr_addr(rev_wa), .wr_data(mad_rsp.res),
    .rd_addr(rev_ra), .rd_data(rev_q)
  );

  rsh_modmul u_mad (
    .clk(clk), .rst_n(rst_n), .req(mad_req), .modulus(modulus), .rsp(mad_rsp)
  );

  // Entry zero of each table is a constant; its memory word is never used.
  assign pre_d = pre_z_r ? '0 : pre_q;
  assign pow_d = pow_z_r ? HW'(1) : pow_q;
  assign rev_d = rev_z_r ? '0 : rev_q;

  // Load position, range checks and the range picked for the current hash.
  assign is_load = (cmd_r.func == rsh_pkg::FUNC_LOAD);
  assign n_eff = done_r ? '0 : len_r;
  assign ok_one = cmd_r.ord_one && (cmd_r.end_one <= len_r);
  assign ok_two = cmd_r.ord_two && (cmd_r.end_two <= len_r);
  assign sel_rev = (cmd_r.func == rsh_pkg::FUNC_PAL) && which_r;
  assign sel_lo = !which_r ? cmd_r.start_one :
                  (sel_rev ? (len_r - cmd_r.end_one) : cmd_r.start_two);
  assign sel_hi = !which_r ? cmd_r.end_one :
                  (sel_rev ? (len_r - cmd_r.start_one) : cmd_r.end_two);
  assign sel_plen = (which_r && !sel_rev) ? cmd_r.len_two : cmd_r.len_one;
  assign tab_d = sel_rev ? rev_d : pre_d;
  assign walk_idx = len_r - i_r - PW'(1);

  // Memory addressing.
  always_comb begin
    char_we = (state_r == S_DISP) && is_load && (n_eff < PW'(rsh_pkg::MAX_LEN));
    char_wa = n_eff[rsh_pkg::CHAR_AW-1:0];
    char_ra = walk_idx[rsh_pkg::CHAR_AW-1:0];
    pre_ra = (state_r == S_DISP) ? n_eff : ((state_r == S_H_B) ? sel_hi : sel_lo);
    pow_ra = (state_r == S_DISP) ? n_eff : sel_plen;
    rev_ra = (state_r == S_H_B) ? sel_hi : sel_lo;
    pow_we = (state_r == S_LD_PW) && mad_rsp.done;
    pre_we = (state_r == S_LD_PH) && mad_rsp.done;
    rev_we = (state_r == S_WALK_W) && mad_rsp.done;
    pow_wa = n_r + PW'(1);
    pre_wa = n_r + PW'(1);
    rev_wa = i_r + PW'(1);
  end

  // Requests to the multiply-add unit.
  always_comb begin
    mad_req = '0;
    mad_req.b = base;
    unique case (state_r)
      S_LD_RD: begin
        mad_req.start = 1'b1;
        mad_req.a = pow_d;
      end
      S_LD_PW: begin
        mad_req.start = mad_rsp.done;
        mad_req.a = tmp_r;
        mad_req.c = (HW + 1)'(cmd_r.char_value);
      end
      S_WALK_RD: begin
        mad_req.start = 1'b1;
        mad_req.a = acc_r;
        mad_req.c = (HW + 1)'($signed(char_q));
      end
      S_H_C: begin
        mad_req.start = 1'b1;
        mad_req.a = tlo_r;
        mad_req.b = pw_r;
        mad_req.c = {1'b0, tab_d};
        mad_req.neg = 1'b1;
      end
      default: mad_req.start = 1'b0;
    endcase
  end

  // Main sequencer.
  always_comb begin
    state_nxt = state_r;
    cmd_nxt = cmd_r;
    len_nxt = len_r;
    n_nxt = n_r;
    i_nxt = i_r;
    done_nxt = done_r;
    which_nxt = which_r;
    tmp_nxt = tmp_r;
    acc_nxt = acc_r;
    h0_nxt = h0_r;
    tlo_nxt = tlo_r;
    pw_nxt = pw_r;
    res_hash_nxt = res_hash_r;
    res_flag_nxt = res_flag_r;
    res_status_nxt = res_status_r;
    out_valid_nxt = out_valid_r && !pop;
    out_hash_nxt = out_hash_r;
    out_flag_nxt = out_flag_r;
    out_status_nxt = out_status_r;
    cmd_pop = 1'b0;
    unique case (state_r)
      S_FETCH: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          cmd_nxt = cmd;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        res_hash_nxt = '0;
        res_flag_nxt = 1'b0;
        res_status_nxt = rsh_pkg::ST_OK;
        unique case (cmd_r.func)
          rsh_pkg::FUNC_LOAD: begin
            // A load after completion starts a new string.
            if (done_r) begin
              len_nxt = '0;
              done_nxt = 1'b0;
            end
            n_nxt = n_eff;
            i_nxt = '0;
            acc_nxt = '0;
            if (n_eff < PW'(rsh_pkg::MAX_LEN)) begin
              state_nxt = S_LD_RD;
            end else if (cmd_r.last_char) begin
              state_nxt = S_WALK;
            end else begin
              state_nxt = S_FETCH;
            end
          end
          rsh_pkg::FUNC_HASH: begin
            which_nxt = 1'b1;
            if (ok_two) begin
              state_nxt = S_H_A;
            end else begin
              res_status_nxt = rsh_pkg::ST_RANGE;
              state_nxt = S_OUT;
            end
          end
          rsh_pkg::FUNC_CMP: begin
            which_nxt = 1'b0;
            if (ok_one && ok_two) begin
              state_nxt = S_H_A;
            end else begin
              res_status_nxt = rsh_pkg::ST_RANGE;
              state_nxt = S_OUT;
            end
          end
          rsh_pkg::FUNC_PAL: begin
            which_nxt = 1'b0;
            if (!done_r) begin
              res_status_nxt = rsh_pkg::ST_NOREV;
              state_nxt = S_OUT;
            end else if (!ok_one) begin
              res_status_nxt = rsh_pkg::ST_RANGE;
              state_nxt = S_OUT;
            end else begin
              state_nxt = S_H_A;
            end
          end
          default: state_nxt = S_FETCH;
        endcase
      end
      S_LD_RD: begin
        tmp_nxt = pre_d;
        state_nxt = S_LD_PW;
      end
      S_LD_PW: begin
        if (mad_rsp.done) begin
          state_nxt = S_LD_PH;
        end
      end
      S_LD_PH: begin
        if (mad_rsp.done) begin
          len_nxt = n_r + PW'(1);
          state_nxt = cmd_r.last_char ? S_WALK : S_FETCH;
        end
      end
      S_WALK: begin
        // Reverse prefix hashes, one stored character per pass.
        if (i_r == len_r) begin
          done_nxt = 1'b1;
          state_nxt = S_FETCH;
        end else begin
          state_nxt = S_WALK_RD;
        end
      end
      S_WALK_RD: state_nxt = S_WALK_W;
      S_WALK_W: begin
        if (mad_rsp.done) begin
          acc_nxt = mad_rsp.res;
          i_nxt = i_r + PW'(1);
          state_nxt = S_WALK;
        end
      end
      S_H_A: state_nxt = S_H_B;
      S_H_B: begin
        tlo_nxt = tab_d;
        pw_nxt = pow_d;
        state_nxt = S_H_C;
      end
      S_H_C: state_nxt = S_H_W;
      S_H_W: begin
        if (mad_rsp.done) begin
          if (!which_r) begin
            h0_nxt = mad_rsp.res;
            which_nxt = 1'b1;
            state_nxt = S_H_A;
          end else begin
            if (cmd_r.func == rsh_pkg::FUNC_HASH) begin
              res_hash_nxt = mad_rsp.res;
            end else begin
              res_flag_nxt = (h0_r == mad_rsp.res);
            end
            state_nxt = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (!out_valid_r || pop) begin
          out_valid_nxt = 1'b1;
          out_hash_nxt = res_hash_r;
          out_flag_nxt = res_flag_r;
          out_status_nxt = res_status_r;
          state_nxt = S_FETCH;
        end
      end
      default: state_nxt = S_FETCH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_FETCH;
      len_r <= '0;
      done_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r <= len_nxt;
      done_r <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r <= cmd_nxt;
    n_r <= n_nxt;
    i_r <= i_nxt;
    which_r <= which_nxt;
    tmp_r <= tmp_nxt;
    acc_r <= acc_nxt;
    h0_r <= h0_nxt;
    tlo_r <= tlo_nxt;
    pw_r <= pw_nxt;
    res_hash_r <= res_hash_nxt;
    res_flag_r <= res_flag_nxt;
    res_status_r <= res_status_nxt;
    out_hash_r <= out_hash_nxt;
    out_flag_r <= out_flag_nxt;
    out_status_r <= out_status_nxt;
    pre_z_r <= (pre_ra == '0);
    pow_z_r <= (pow_ra == '0);
    rev_z_r <= (rev_ra == '0);
  end

  assign empty = !out_valid_r;
  assign hash_value = out_hash_r;
  assign answer_flag = out_flag_r;
  assign status = out_status_r;

  // The loaded length never exceeds the store.
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= PW'(rsh_pkg::MAX_LEN))
    else $error("loaded length beyond store");

  // The multiply-add unit is only started when it is free.
  a_mad_free: assert property (@(posedge clk) disable iff (!rst_n)
    mad_req.start |-> !mad_rsp.busy)
    else $error("multiply-add started while busy");

  // The string is marked complete only at the end of the reverse walk.
  a_done_walk: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(done_r) |-> $past(state_r) == S_WALK)
    else $error("string completed outside the walk");

  // A finished result lands in a free output register.
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && !out_valid_r) |=> out_valid_r)
    else $error("result not delivered to output register");

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the rolling substring hash block.
module testbench;
  import rsh_pkg::*;

  localparam int LIMIT = 2000000;

  typedef struct {
    bit [HW-1:0] hash_value;
    bit          answer_flag;
    bit [1:0]    status;
  } hash_answer_t;

  // Scoreboard: holds its own copy of the string tables and the answers still owed.
  class hash_ledger;
    bit [HW-1:0]     modulus_r = MODULUS_RST;
    bit [HW-1:0]     base_r = BASE_RST;
    bit [7:0]        chars [MAX_LEN];
    bit [HW-1:0]     fwd [MAX_LEN+1];
    bit [HW-1:0]     pw [MAX_LEN+1];
    bit [HW-1:0]     rev [MAX_LEN+1];
    int unsigned     len = 0;
    bit              complete = 0;
    hash_answer_t    owed [$];
    int              mismatches = 0;

    function new();
      fwd[0] = 0;
      pw[0] = 1;
      rev[0] = 0;
    endfunction

    function longint unsigned eff_mod();
      return (modulus_r < 2) ? 1 : modulus_r;
    endfunction

    function longint unsigned char_res(bit [7:0] raw, longint unsigned m);
      if (raw < 8'h80) return raw % m;
      return (m - ((256 - raw) % m)) % m;
    endfunction

    function longint unsigned mad(longint unsigned a, longint unsigned b,
                                  longint unsigned c, longint unsigned m);
      return ((a % m) * (b % m) + (c % m)) % m;
    endfunction

    // Hash of [lo,hi) from either prefix table.
    function longint unsigned span_hash(bit use_rev, int unsigned lo, int unsigned hi,
                                        longint unsigned m);
      longint unsigned tlo, thi, neg;
      tlo = use_rev ? rev[lo] : fwd[lo];
      thi = use_rev ? rev[hi] : fwd[hi];
      neg = (m - tlo % m) % m;
      return mad(neg, pw[hi - lo], thi, m);
    endfunction

    function bit span_ok(int unsigned lo, int unsigned hi);
      return lo <= hi && hi <= len;
    endfunction

    function void write_reg(bit [CFG_IDX_W-1:0] idx, bit [HW-1:0] val);
      if (idx == CFG_MODULUS) modulus_r = val;
      else base_r = val;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    // Apply one accepted request and record the answer it owes, if any.
    function void note_request(bit [1:0] func, bit [7:0] ch, bit last,
                               int unsigned s1, int unsigned e1,
                               int unsigned s2, int unsigned e2);
      longint unsigned m;
      hash_answer_t a;
      int unsigned n;
      m = eff_mod();
      a.hash_value = 0;
      a.answer_flag = 0;
      a.status = ST_OK;
      if (func == FUNC_LOAD) begin
        if (complete) begin
          len = 0;
          complete = 0;
        end
        if (len < MAX_LEN) begin
          chars[len] = ch;
          pw[len+1] = mad(pw[len], base_r, 0, m);
          fwd[len+1] = mad(fwd[len], base_r, char_res(ch, m), m);
          len++;
        end
        if (last) begin
          rev[0] = 0;
          for (int i = 0; i < len; i++)
            rev[i+1] = mad(rev[i], base_r, char_res(chars[len-1-i], m), m);
          complete = 1;
        end
        return;
      end
      if (func == FUNC_HASH) begin
        if (span_ok(s2, e2)) a.hash_value = span_hash(0, s2, e2, m);
        else a.status = ST_RANGE;
      end else if (func == FUNC_CMP) begin
        if (span_ok(s1, e1) && span_ok(s2, e2))
          a.answer_flag = span_hash(0, s1, e1, m) == span_hash(0, s2, e2, m);
        else a.status = ST_RANGE;
      end else begin
        n = len;
        if (!complete) a.status = ST_NOREV;
        else if (!span_ok(s1, e1)) a.status = ST_RANGE;
        else a.answer_flag = span_hash(0, s1, e1, m) == span_hash(1, n - e1, n - s1, m);
      end
      owed.insert(owed.size(), a);
    endfunction

    // Compare one popped result with the oldest owed answer.
    function void check_result(bit [HW-1:0] hv, bit flag, bit [1:0] st);
      hash_answer_t a;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: hash %0d flag %0d status %0d", hv, flag, st);
        return;
      end
      a = owed.pop_front();
      if (a.hash_value !== hv || a.answer_flag !== flag || a.status !== st) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected hash %0d flag %0d status %0d, got %0d %0d %0d",
                   a.hash_value, a.answer_flag, a.status, hv, flag, st);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n;
  logic push, pop, full, empty;
  logic [1:0] in_func;
  logic signed [CHAR_W-1:0] in_char_value;
  logic in_last_char;
  logic [POS_W-1:0] in_start_one, in_end_one, in_start_two, in_end_two;
  logic [HW-1:0] out_hash_value;
  logic out_answer_flag;
  logic [1:0] out_status;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [HW-1:0] cfg_data;

  hash_ledger ledger = new();
  bit steady = 0;
  bit hold_req = 0;
  int cycles = 0;
  int sent = 0;

  rolling_substring_hash uut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_func(in_func), .in_char_value(in_char_value), .in_last_char(in_last_char),
    .in_start_one(in_start_one), .in_end_one(in_end_one),
    .in_start_two(in_start_two), .in_end_two(in_end_two),
    .empty(empty), .pop(pop), .out_hash_value(out_hash_value),
    .out_answer_flag(out_answer_flag), .out_status(out_status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Result side: random pop, with a long hold-off when one is requested.
  initial begin
    int hold_left;
    hold_left = 0;
    pop <= 0;
    forever begin
      @(posedge clk);
      if (pop && !empty) ledger.check_result(out_hash_value, out_answer_flag, out_status);
      if (hold_req) begin
        hold_req = 0;
        hold_left = 3000;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 0;
      end else begin
        pop <= steady || ($urandom_range(99) >= 30);
      end
    end
  end

  // Offer one request and wait until it is accepted; entered at a clock edge.
  task automatic offer(bit [1:0] f, bit [7:0] c, bit l, int unsigned s1, int unsigned e1,
                       int unsigned s2, int unsigned e2);
    if (!steady && $urandom_range(99) < 30) begin
      push <= 0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    push <= 1;
    in_func <= f;
    in_char_value <= c;
    in_last_char <= l;
    in_start_one <= s1;
    in_end_one <= e1;
    in_start_two <= s2;
    in_end_two <= e2;
    @(posedge clk);
    while (full) @(posedge clk);
    ledger.note_request(f, c, l, s1, e1, s2, e2);
    sent++;
  endtask

  // Stop offering until every owed answer has come back.
  task automatic wait_drained();
    push <= 0;
    while (ledger.pending() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // A query behind all loads proves the block idle once its answer is back.
  task automatic settle();
    offer(FUNC_HASH, 0, 0, 0, 0, 0, 0);
    wait_drained();
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(bit [CFG_IDX_W-1:0] idx, bit [HW-1:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    ledger.write_reg(idx, val);
    cfg_valid <= 0;
  endtask

  // Random query, mostly well-formed against the current string.
  task automatic random_query(int unsigned n);
    bit [1:0] f;
    int unsigned s1, e1, s2, e2;
    f = $urandom_range(3, 1);
    s1 = $urandom_range(n); e1 = $urandom_range(n, s1);
    s2 = $urandom_range(n); e2 = $urandom_range(n, s2);
    if ($urandom_range(99) < 20) begin
      s2 = s1;
      e2 = e1;
    end
    if ($urandom_range(99) < 15) begin
      s1 = $urandom_range(2047); e1 = $urandom_range(2047);
      s2 = $urandom_range(2047); e2 = $urandom_range(2047);
    end
    offer(f, $urandom_range(255), $urandom_range(1), s1, e1, s2, e2);
  endtask

  // One string of random content, half of them palindromes, then queries.
  task automatic random_string(int unsigned n);
    bit [7:0] txt [];
    txt = new[n];
    for (int i = 0; i < n; i++) txt[i] = $urandom_range(255);
    if ($urandom_range(1))
      for (int i = 0; i < n / 2; i++) txt[n-1-i] = txt[i];
    for (int i = 0; i < n; i++) begin
      offer(FUNC_LOAD, txt[i], i == n - 1, $urandom_range(2047), $urandom_range(2047),
            $urandom_range(2047), $urandom_range(2047));
      if ($urandom_range(99) < 10) random_query(i + 1);
    end
    repeat ($urandom_range(8, 2)) random_query(n > MAX_LEN ? MAX_LEN : n);
  endtask

  task automatic random_phase(int items);
    int stop;
    stop = sent + items;
    while (sent < stop) random_string($urandom_range(99) < 5 ? $urandom_range(120, 40)
                                                             : $urandom_range(24, 1));
  endtask

  initial begin
    bit [HW-1:0] mods [8];
    bit [HW-1:0] bases [8];
    mods = '{30'd998244353, 30'd0, 30'd1, 30'd2, 30'h3FFFFFFF, 30'd7, 30'd1000003,
             30'd1073741789};
    bases = '{30'd131, 30'd5, 30'd7, 30'd3, 30'h3FFFFFFE, 30'd100, 30'd0, 30'd31};
    rst_n <= 0;
    push <= 0;
    in_func <= FUNC_LOAD;
    in_char_value <= 0;
    in_last_char <= 0;
    in_start_one <= 0; in_end_one <= 0; in_start_two <= 0; in_end_two <= 0;
    cfg_valid <= 0;
    cfg_index <= CFG_MODULUS;
    cfg_data <= 0;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: queries on an empty store, then a short palindrome.
    offer(FUNC_PAL, 0, 0, 0, 0, 0, 0);
    offer(FUNC_HASH, 0, 0, 0, 0, 0, 0);
    offer(FUNC_HASH, 0, 0, 0, 0, 0, 1);
    offer(FUNC_CMP, 0, 0, 0, 0, 0, 0);
    offer(FUNC_LOAD, 8'h05, 0, 0, 0, 0, 0);
    offer(FUNC_PAL, 0, 0, 0, 1, 0, 0);
    offer(FUNC_LOAD, 8'h80, 0, 0, 0, 0, 0);
    offer(FUNC_LOAD, 8'h05, 1, 0, 0, 0, 0);
    offer(FUNC_PAL, 0, 0, 0, 3, 0, 0);
    offer(FUNC_PAL, 0, 0, 1, 1, 0, 0);
    offer(FUNC_PAL, 0, 0, 2, 1, 0, 0);
    offer(FUNC_PAL, 0, 0, 0, 4, 0, 0);
    offer(FUNC_HASH, 0, 0, 0, 0, 0, 3);
    offer(FUNC_HASH, 0, 0, 0, 0, 3, 2);
    offer(FUNC_CMP, 0, 0, 0, 1, 2, 3);
    offer(FUNC_CMP, 0, 0, 2047, 2047, 2047, 2047);
    // Load after completion starts a new string.
    offer(FUNC_LOAD, 8'h7F, 0, 2047, 2047, 2047, 2047);
    offer(FUNC_LOAD, 8'h7F, 1, 0, 0, 0, 0);
    offer(FUNC_PAL, 0, 0, 0, 2, 0, 0);
    offer(FUNC_CMP, 0, 0, 0, 1, 1, 2);
    offer(FUNC_HASH, 8'hFF, 1, 0, 0, 1, 2);

    // Pressure: results held back while requests keep coming.
    hold_req = 1;
    repeat (40) random_query(2);
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      settle();
      write_reg(CFG_MODULUS, mods[p]);
      write_reg(CFG_BASE, bases[p]);
      @(posedge clk);
      if (p == 4) steady = 1;
      random_phase(30);
      steady = 0;
      if (p == 6) random_string(1030);
    end

    wait_drained();
    repeat (100) @(posedge clk);
    if (ledger.mismatches == 0 && ledger.pending() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end
endmodule
